[design/kvt_pkg.sv]
// Package for the key/value table: sizes, operation and status codes,
// and the structs passed along the cell chain. No dependencies.
package kvt_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int OP_BITS    = 3;
	localparam int STATUS_BITS = 2;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int COUNT_BITS = $clog2(ENTRIES + 1);

	typedef enum logic [OP_BITS-1:0] {
		OP_LOOKUP = 3'd0,
		OP_ACCESS = 3'd1,
		OP_WRITE  = 3'd2,
		OP_ERASE  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		UPD_INSERT,
		UPD_VALUE,
		UPD_ERASE,
		UPD_CLEAR
	} upd_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	// Search token that travels one cell per cycle.
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic                  hit;
		logic [IDX_BITS-1:0]   hit_idx;
		logic [VALUE_BITS-1:0] hit_val;
		logic                  free;
		logic [IDX_BITS-1:0]   free_idx;
	} tok_t;

	// Update broadcast to every cell once a search has finished.
	typedef struct packed {
		logic                  en;
		upd_kind_t             kind;
		logic [IDX_BITS-1:0]   idx;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} upd_t;

endpackage

[design/key_value_table.sv]
// An accepted item's search token walks the chain of ENTRIES slot cells one cell per
// cycle; the result is then decided and registered once the output side is free.
// No new item is taken until that result is committed (in_stall is high meanwhile).
// A new item may be accepted while the previous result still waits to be taken.
// Reset (arst_n low, asynchronous) frees every slot and zeroes the entry count.
module key_value_table import kvt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [OP_BITS-1:0]           op,
	input  logic signed [KEY_BITS-1:0]   key,
	input  logic signed [VALUE_BITS-1:0] value_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [VALUE_BITS-1:0] value_out,
	output logic [STATUS_BITS-1:0]       status,
	output logic [COUNT_BITS-1:0]        entry_count
);

	state_t                state_q, state_nxt;
	logic [OP_BITS-1:0]    op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [COUNT_BITS-1:0] live_q, live_nxt;
	tok_t                  fin_q;
	tok_t                  launch;
	tok_t                  chain [ENTRIES+1];
	upd_t                  upd;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] vout_q, vout_nxt;
	logic [STATUS_BITS-1:0] status_q;
	status_t               status_nxt;
	logic                  accept;
	logic                  out_free;
	logic                  commit;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		launch          = '0;
		launch.valid    = accept;
		launch.key      = key;
	end

	assign chain[0] = launch;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_BITS'(i)),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1]),
			.upd     (upd)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (chain[ENTRIES].valid) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					commit    = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value_in;
		end
		if ((state_q == S_SCAN) && chain[ENTRIES].valid) begin
			fin_q <= chain[ENTRIES];
		end
	end

	// Decision once the token has seen every slot.
	always_comb begin
		upd        = '0;
		upd.en     = commit;
		upd.key    = key_q;
		upd.value  = val_q;
		upd.kind   = UPD_VALUE;
		upd.idx    = fin_q.hit_idx;
		vout_nxt   = '0;
		status_nxt = ST_MISS;
		live_nxt   = live_q;
		case (op_q)
			OP_CLEAR: begin
				upd.kind   = UPD_CLEAR;
				live_nxt   = '0;
				status_nxt = ST_HIT;
			end
			OP_ERASE: begin
				upd.kind = UPD_ERASE;
				if (fin_q.hit) begin
					vout_nxt   = fin_q.hit_val;
					status_nxt = ST_HIT;
					if (live_q != '0) live_nxt = live_q - COUNT_BITS'(1);
				end else begin
					upd.en = 1'b0;
				end
			end
			OP_ACCESS, OP_WRITE: begin
				if (fin_q.hit) begin
					status_nxt = ST_HIT;
					if (op_q == OP_WRITE) begin
						vout_nxt = val_q;
					end else begin
						vout_nxt = fin_q.hit_val;
						upd.en   = 1'b0;
					end
				end else if (fin_q.free) begin
					upd.kind   = UPD_INSERT;
					upd.idx    = fin_q.free_idx;
					// An access inserts the key with a zero value.
					if (op_q != OP_WRITE) upd.value = '0;
					vout_nxt   = upd.value;
					status_nxt = ST_NEW;
					live_nxt   = live_q + COUNT_BITS'(1);
				end else begin
					upd.en     = 1'b0;
					status_nxt = ST_FULL;
				end
			end
			default: begin
				upd.en = 1'b0;
				if (fin_q.hit) begin
					vout_nxt   = fin_q.hit_val;
					status_nxt = ST_HIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				live_q      <= live_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			vout_q   <= vout_nxt;
			status_q <= status_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = vout_q;
	assign status      = status_q;
	assign entry_count = live_q;

endmodule

[design/kvt_cell.sv]
// One slot of the key/value table and one stage of the search chain.
// Depends on kvt_pkg.
module kvt_cell import kvt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_BITS-1:0] my_idx,
	input  tok_t                tok_in,
	output tok_t                tok_out,
	input  upd_t                upd
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	tok_t                  tok_q;
	tok_t                  tok_nxt;
	logic                  sel;

	// Only the first match and the first free slot along the chain are kept.
	always_comb begin
		tok_nxt = tok_in;
		if (valid_q) begin
			if (!tok_in.hit && (key_q == tok_in.key)) begin
				tok_nxt.hit     = 1'b1;
				tok_nxt.hit_idx = my_idx;
				tok_nxt.hit_val = val_q;
			end
		end else if (!tok_in.free) begin
			tok_nxt.free     = 1'b1;
			tok_nxt.free_idx = my_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign sel = upd.en && (upd.idx == my_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.en && (upd.kind == UPD_CLEAR)) begin
			valid_q <= 1'b0;
		end else if (sel && (upd.kind == UPD_ERASE)) begin
			valid_q <= 1'b0;
		end else if (sel && (upd.kind == UPD_INSERT)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && (upd.kind == UPD_INSERT)) begin
			key_q <= upd.key;
		end
		if (sel && ((upd.kind == UPD_INSERT) || (upd.kind == UPD_VALUE))) begin
			val_q <= upd.value;
		end
	end

	assign tok_out = tok_q;

endmodule

[design/kvt_checker.sv]
// Port-level checks for the key/value table, bound to the top level.
// Depends on kvt_pkg.
module kvt_checker import kvt_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [VALUE_BITS-1:0] value_out,
	input logic [STATUS_BITS-1:0]       status,
	input logic [COUNT_BITS-1:0]        entry_count
);

	// A held result keeps its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status)
			&& $stable(entry_count))
		else $error("result changed while stalled");

	// The block is busy for the cycle after taking an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while a search is running");

	// A refused insert only happens on a full table.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> entry_count == COUNT_BITS'(ENTRIES))
		else $error("table full reported below capacity");

	// The entry count never exceeds the capacity.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= COUNT_BITS'(ENTRIES))
		else $error("entry count above capacity");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

[verif/key_value_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the key/value table: keeps its own copy of the slots, predicts each
// result from the accepted input items and compares it with the output side.
// Depends on kvt_pkg.
module key_value_table_checker import kvt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [OP_BITS-1:0]           op,
	input  logic signed [KEY_BITS-1:0]   key,
	input  logic signed [VALUE_BITS-1:0] value_in,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [VALUE_BITS-1:0] value_out,
	input  logic [STATUS_BITS-1:0]       status,
	input  logic [COUNT_BITS-1:0]        entry_count,
	output int                           fail_count,
	output int                           pending
);

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		status_t                      status;
		logic [COUNT_BITS-1:0]        count;
	} kv_result_t;

	localparam int REPORT_CAP = 200;

	logic                  slot_used[ENTRIES];
	logic [KEY_BITS-1:0]   slot_key_copy[ENTRIES];
	logic [VALUE_BITS-1:0] slot_value_copy[ENTRIES];
	logic [COUNT_BITS-1:0] live_entries;
	kv_result_t            expected_results[$];
	int                    reported;

	// Applies one operation to the copy of the table and returns its result.
	function automatic kv_result_t apply_table_op(logic [OP_BITS-1:0] code,
			logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		kv_result_t r;
		int hit_idx;
		int free_idx;
		hit_idx = -1;
		free_idx = -1;
		r.value = '0;
		r.status = ST_MISS;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i]) begin
				if (hit_idx < 0 && slot_key_copy[i] == k)
					hit_idx = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		case (code)
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					slot_used[i] = 1'b0;
				live_entries = '0;
				r.status = ST_HIT;
			end
			OP_ERASE: begin
				if (hit_idx >= 0) begin
					r.value = slot_value_copy[hit_idx];
					slot_used[hit_idx] = 1'b0;
					if (live_entries > 0)
						live_entries = live_entries - COUNT_BITS'(1);
					r.status = ST_HIT;
				end
			end
			OP_ACCESS, OP_WRITE: begin
				if (hit_idx >= 0) begin
					if (code == OP_WRITE)
						slot_value_copy[hit_idx] = v;
					r.value = slot_value_copy[hit_idx];
					r.status = ST_HIT;
				end else if (free_idx >= 0) begin
					slot_used[free_idx] = 1'b1;
					slot_key_copy[free_idx] = k;
					slot_value_copy[free_idx] = (code == OP_WRITE) ? v : '0;
					r.value = slot_value_copy[free_idx];
					live_entries = live_entries + COUNT_BITS'(1);
					r.status = ST_NEW;
				end else begin
					r.status = ST_FULL;
				end
			end
			default: begin
				// Lookup, and the unused codes, which behave as lookup.
				if (hit_idx >= 0) begin
					r.value = slot_value_copy[hit_idx];
					r.status = ST_HIT;
				end
			end
		endcase
		r.count = live_entries;
		return r;
	endfunction

	always @(posedge clk) begin
		kv_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_key_copy[i] = '0;
				slot_value_copy[i] = '0;
			end
			live_entries = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			reported = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (reported < REPORT_CAP)
						$display({"%0t: result with no item outstanding: ",
							"value %0d status %0d count %0d"},
							$time, value_out, status, entry_count);
					reported++;
				end else begin
					want = expected_results.pop_front();
					if (value_out !== want.value || status !== want.status
							|| entry_count !== want.count) begin
						fail_count++;
						if (reported < REPORT_CAP)
							$display({"%0t: mismatch: expected value %0d status %0d ",
								"count %0d, actual value %0d status %0d count %0d"},
								$time, want.value, want.status, want.count,
								value_out, status, entry_count);
						reported++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_table_op(op, key, value_in));
			pending = expected_results.size();
		end
	end

endmodule

[verif/key_value_table_tb.sv]
`timescale 1ns / 1ps
// Testbench top for key_value_table: drives directed then random operations with
// varying idle and stall pressure, and gives the verdict from the checker.
// Depends on kvt_pkg, key_value_table and key_value_table_checker.
module key_value_table_tb;
	import kvt_pkg::*;

	localparam int POOL_SIZE = 20;
	localparam int PHASE_ITEMS = 275;
	localparam logic [KEY_BITS-1:0]   KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
	localparam logic [KEY_BITS-1:0]   KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [OP_BITS-1:0]    OP_SPARE_LO = OP_CLEAR + OP_BITS'(1);
	localparam logic [OP_BITS-1:0]    OP_SPARE_HI = '1;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [OP_BITS-1:0]           op = '0;
	logic signed [KEY_BITS-1:0]   key = '0;
	logic signed [VALUE_BITS-1:0] value_in = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [VALUE_BITS-1:0] value_out;
	logic [STATUS_BITS-1:0]       status;
	logic [COUNT_BITS-1:0]        entry_count;
	int                           fail_count;
	int                           pending;

	int                           idle_pct = 0;
	int                           stall_pct = 0;
	logic [KEY_BITS-1:0]          key_pool[POOL_SIZE];

	key_value_table u_top (.*);
	key_value_table_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [OP_BITS-1:0] code, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = code;
		key = k;
		value_in = v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Writes dominate over erases so that the table often runs full.
	function automatic logic [OP_BITS-1:0] pick_op();
		int w;
		w = $urandom_range(99);
		if (w < 18) return OP_LOOKUP;
		if (w < 36) return OP_ACCESS;
		if (w < 66) return OP_WRITE;
		if (w < 92) return OP_ERASE;
		if (w < 95) return OP_CLEAR;
		return OP_BITS'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
	endfunction

	// A small pool of keys gives plenty of hits; the rest are noise.
	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return KEY_BITS'($urandom);
	endfunction

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_LOOKUP, '0, '0);
		send_item(OP_ERASE, '0, '0);
		send_item(OP_WRITE, KEY_MIN, VAL_MAX);
		send_item(OP_WRITE, KEY_MAX, VAL_MIN);
		send_item(OP_ACCESS, '0, VAL_MAX);
		send_item(OP_ACCESS, KEY_MIN, '0);
		send_item(OP_WRITE, KEY_MAX, '1);
		send_item(OP_ERASE, KEY_MIN, '0);
		// The first write reuses the slot just freed; the rest fill the table.
		for (int i = 0; i < ENTRIES - 2; i++)
			send_item(OP_WRITE, KEY_BITS'(100 + i), VALUE_BITS'($urandom));
		send_item(OP_ACCESS, KEY_BITS'(555), '0);
		send_item(OP_WRITE, KEY_BITS'(556), VALUE_BITS'(9));
		send_item(OP_WRITE, KEY_MAX, VALUE_BITS'(7));
		send_item(OP_SPARE_LO, KEY_MAX, '0);
		send_item(OP_SPARE_HI, KEY_BITS'(999), '1);
		send_item(OP_CLEAR, '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			key_pool[0] = KEY_MIN;
			key_pool[1] = KEY_MAX;
			key_pool[2] = '0;
			key_pool[3] = '1;
			for (int i = 4; i < POOL_SIZE; i++)
				key_pool[i] = KEY_BITS'($urandom);
			repeat (PHASE_ITEMS)
				send_item(pick_op(), pick_key(), VALUE_BITS'($urandom));
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (2 * (ENTRIES + 2)) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
